### rtl/bda_pkg.sv
// bda_pkg: shared types and constants for the binary to decimal ascii converter
// no dependencies

package bda_pkg;

  localparam int BIN_W  = 32;              // input value width
  localparam int DIG_N  = 10;              // decimal digits of a 32-bit value
  localparam int BCD_W  = 4 * DIG_N;       // packed bcd width
  localparam int CHAR_W = 6;               // output character width
  localparam int CNT_W  = 5;               // shift step counter width
  localparam int IDX_W  = 4;               // digit index width

  localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(BIN_W - 1);
  localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(DIG_N - 1);
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // capture value, clear bcd and counters
    logic shift;    // one add-3 and shift step
    logic advance;  // move to next digit
    logic emit;     // present current digit on the result ports
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic conv_last;   // current shift step is the final one
    logic digit_zero;  // current digit is zero
    logic digit_last;  // current digit is the least significant
  } sts_t;

endpackage

### rtl/binary_to_decimal_ascii.sv
// binary_to_decimal_ascii: top level of the binary to decimal ascii converter
// depends on bda_pkg, bda_ctrl and bda_dpath

// converts one unsigned 32-bit value per transaction into its decimal text,
// one ascii digit per result, most significant first, leading zeros dropped;
// zero gives a single '0' and the final digit carries out_last_digit.
// a transaction is taken when start is high and busy is low. the value is
// converted by a double-dabble register, one shift-and-add-3 step a cycle
// for each of the 32 input bits; the digit scan then visits each of the ten
// digit positions in turn, skipping leading zeros and emitting the rest. a
// transaction's length does not depend on the value; it is set by the 32-step
// conversion loop and the fixed ten-position scan, and the block takes no new
// value until the scan is done. each digit goes through the result register as
// the scan reaches it, the units digit last. each result shows for a single
// cycle with out_valid high and cannot be held off by the receiver; the last
// result is still on the ports as busy drops

module binary_to_decimal_ascii (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [bda_pkg::BIN_W-1:0]  in_value,
  output logic                       out_valid,
  output logic [bda_pkg::CHAR_W-1:0] out_digit_char,
  output logic                       out_last_digit
);

  // command and status between controller and datapath
  bda_pkg::cmd_t cmd;
  bda_pkg::sts_t sts;

  // sequencer: load, convert, skip leading zeros, emit
  bda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // shift register, digit scanner and registered result ports
  bda_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

### rtl/bda_dpath.sv
// bda_dpath: double-dabble shift register, digit scanner and result register
// depends on bda_pkg

module bda_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bda_pkg::BIN_W-1:0]     in_value,
  input  bda_pkg::cmd_t                 cmd,
  output bda_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic [bda_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last_digit
);

  logic [bda_pkg::BIN_W-1:0]  bin_r,  bin_nxt;
  logic [bda_pkg::BCD_W-1:0]  bcd_r,  bcd_nxt;
  logic [bda_pkg::BCD_W-1:0]  bcd_adj;
  logic [bda_pkg::CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [bda_pkg::IDX_W-1:0]  idx_r,  idx_nxt;
  logic                       valid_r;
  logic [bda_pkg::CHAR_W-1:0] char_r;
  logic                       last_r;
  logic [3:0]                 cur_digit;

  // add 3 to every digit of five or more
  always_comb begin
    for (int i = 0; i < bda_pkg::DIG_N; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  assign cur_digit = bcd_r[bda_pkg::BCD_W-1 -: 4];

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (cmd.load) begin
      bin_nxt = in_value;
      bcd_nxt = '0;
      cnt_nxt = '0;
      idx_nxt = '0;
    end else if (cmd.shift) begin
      {bcd_nxt, bin_nxt} = {bcd_adj[bda_pkg::BCD_W-2:0], bin_r, 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.advance) begin
      bcd_nxt = {bcd_r[bda_pkg::BCD_W-5:0], 4'd0};
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    if (cmd.emit) begin
      char_r <= bda_pkg::ASCII_ZERO + {2'b00, cur_digit};
      last_r <= (idx_r == bda_pkg::LAST_DIGIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  assign sts.conv_last  = (cnt_r == bda_pkg::LAST_STEP);
  assign sts.digit_zero = (cur_digit == 4'd0);
  assign sts.digit_last = (idx_r == bda_pkg::LAST_DIGIT);

  assign out_valid      = valid_r;
  assign out_digit_char = char_r;
  assign out_last_digit = last_r;

endmodule

### rtl/bda_ctrl.sv
// bda_ctrl: sequencing state machine for conversion and digit emission
// depends on bda_pkg

module bda_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bda_pkg::sts_t sts,
  output bda_pkg::cmd_t cmd,
  output logic          busy
);

  bda_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bda_pkg::ST_IDLE: begin
        if (start) state_nxt = bda_pkg::ST_CONV;
      end
      bda_pkg::ST_CONV: begin
        if (sts.conv_last) state_nxt = bda_pkg::ST_SCAN;
      end
      bda_pkg::ST_SCAN: begin
        if (sts.digit_last) begin
          state_nxt = bda_pkg::ST_IDLE;
        end else if (!sts.digit_zero) begin
          state_nxt = bda_pkg::ST_EMIT;
        end
      end
      bda_pkg::ST_EMIT: begin
        if (sts.digit_last) state_nxt = bda_pkg::ST_IDLE;
      end
      default: state_nxt = bda_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      bda_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      bda_pkg::ST_CONV: begin
        cmd.shift = 1'b1;
      end
      bda_pkg::ST_SCAN: begin
        // leading zeros are dropped, the units digit always goes out
        cmd.emit    = !sts.digit_zero || sts.digit_last;
        cmd.advance = !sts.digit_last;
      end
      bda_pkg::ST_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.advance = !sts.digit_last;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

### verif/binary_to_decimal_ascii_tb.sv
// binary_to_decimal_ascii_tb: self-checking testbench for the decimal text converter
// depends on bda_pkg and the binary_to_decimal_ascii top level
// directed edge values, then shaped random values, predicted digit by digit

module binary_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RADIX        = 10;
  localparam int  N_RANDOM     = 470;
  localparam int  N_DIRECTED   = 23;
  localparam int  END_CYCLES   = 64;       // longer than a whole transaction
  localparam int  CYCLE_LIMIT  = 400000;
  localparam longint MAX_VALUE = 64'hFFFF_FFFF;

  // one value waiting to be offered, with how the sender behaves before it
  typedef struct {
    logic [bda_pkg::BIN_W-1:0] value;
    int                        idle_pct;  // chance per cycle of holding start low first
    bit                        drain;     // hold off until every digit is back
  } conv_req_t;

  // one expected digit character
  typedef struct {
    logic [bda_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [bda_pkg::BIN_W-1:0]  in_value = '0;
  logic                       out_valid;
  logic [bda_pkg::CHAR_W-1:0] out_digit_char;
  logic                       out_last_digit;

  conv_req_t value_q [$];   // values not yet offered
  digit_t    digit_q [$];   // digits still to come, oldest first

  int issued_cnt   = 0;     // values put on the input ports
  int accepted_cnt = 0;     // values taken by the block
  int digits_seen  = 0;
  int drain_cnt    = 0;
  int error_cnt    = 0;
  int cycle_cnt    = 0;
  int burst_left   = 0;     // values still to go with no idling

  binary_to_decimal_ascii uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction: split the value into decimal digits, least significant first,
  // then queue them most significant first; only the units digit is marked
  // ---------------------------------------------------------------------------
  function automatic void queue_expected_digits(input logic [bda_pkg::BIN_W-1:0] value);
    logic [3:0]                units_first [$];
    logic [bda_pkg::BIN_W-1:0] rem;
    digit_t                    d;
    rem = value;
    do begin
      units_first.push_back(4'(rem % RADIX));
      rem = rem / RADIX;
    end while (rem != 0);
    for (int i = units_first.size() - 1; i >= 0; i--) begin
      d.ch   = bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(units_first[i]);
      d.last = (i == 0);
      digit_q.push_back(d);
    end
  endfunction

  function automatic longint ten_pow(input int n);
    longint p;
    p = 1;
    repeat (n) p = p * RADIX;
    return p;
  endfunction

  // random values spread over digit counts, sparse digits and the edges,
  // since plain 32-bit random values are mostly ten digits long
  function automatic logic [bda_pkg::BIN_W-1:0] pick_value();
    longint v;
    longint lo;
    longint hi;
    int     n;
    int     d;
    v = 0;
    case ($urandom_range(4, 0))
      0: v = longint'($urandom());
      1: begin
        // uniform digit count, uniform value within it
        n  = $urandom_range(10, 1);
        lo = (n == 1) ? 0 : ten_pow(n - 1);
        hi = ten_pow(n) - 1;
        if (hi > MAX_VALUE) hi = MAX_VALUE;
        v = lo + longint'($urandom_range(32'(hi - lo), 0));
      end
      2: begin
        // about half of the digits after the first are zero
        n = $urandom_range(10, 1);
        for (int i = 0; i < n; i++) begin
          if (i == 0) d = $urandom_range((n == 10) ? 3 : 9, 1);
          else if ($urandom_range(1, 0) == 1) d = 0;
          else d = $urandom_range(9, 1);
          v = v * RADIX + d;
        end
      end
      3: begin
        // either side of a power of ten
        v = ten_pow($urandom_range(9, 0)) + $urandom_range(6, 0) - 3;
        if (v < 0) v = 0;
      end
      default: v = MAX_VALUE - $urandom_range(7, 0);
    endcase
    return v[bda_pkg::BIN_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0d] mismatch: %s", cycle_cnt, what);
    error_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: inputs change on the falling edge; a value stays on the ports with
  // start high until the block has taken it, then the next one, or a gap
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    conv_req_t req;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accepted_cnt != issued_cnt) begin
      // transaction still waiting for busy to drop: hold everything
    end else if (value_q.size() == 0) begin
      start    <= 1'b0;
      in_value <= $urandom();
    end else if (value_q[0].drain && digit_q.size() != 0) begin
      // pause until every outstanding digit has come back
      start    <= 1'b0;
      in_value <= $urandom();
    end else if (burst_left == 0 && $urandom_range(99, 0) < value_q[0].idle_pct) begin
      start    <= 1'b0;
      in_value <= $urandom();
    end else begin
      req = value_q.pop_front();
      if (req.drain) drain_cnt++;
      in_value <= req.value;
      start    <= 1'b1;
      issued_cnt++;
      if (burst_left > 0) burst_left--;
      else if ($urandom_range(15, 0) == 0) burst_left = $urandom_range(24, 8);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: sampled on the rising edge; a taken transaction queues its digits,
  // each strobed result is checked against the oldest expected digit
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    digit_t want;
    cycle_cnt++;
    if (rst_n) begin
      if (start && !busy) begin
        queue_expected_digits(in_value);
        accepted_cnt++;
      end
      if (out_valid) begin
        digits_seen++;
        if (digit_q.size() == 0) begin
          report_mismatch($sformatf("digit 0x%0h last %0b with nothing expected",
                                    out_digit_char, out_last_digit));
        end else begin
          want = digit_q.pop_front();
          if (out_digit_char !== want.ch)
            report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
                                      out_digit_char, want.ch));
          if (out_last_digit !== want.last)
            report_mismatch($sformatf("last_digit %0b, expected %0b",
                                      out_last_digit, want.last));
        end
      end
    end
  end

  // timeout guard
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [bda_pkg::BIN_W-1:0] directed [N_DIRECTED];
    conv_req_t                 req;
    int                        third;

    directed = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000, 32'd9999,
      32'd100000, 32'd999999, 32'd10000000, 32'd99999999, 32'd1000000000,
      32'd999999999, 32'd1000000001, 32'd4294967295, 32'd4294967294,
      32'd2147483648, 32'd2147483647, 32'd4000000000, 32'd3999999999,
      32'h5555_5555, 32'hAAAA_AAAA
    };

    // directed edges first, with the lighter sender idling
    foreach (directed[i]) begin
      req.value    = directed[i];
      req.idle_pct = 27;
      req.drain    = 1'b0;
      value_q.push_back(req);
    end

    // random part in three phases: light idling, heavy idling, none;
    // each phase opens after all earlier digits are back
    third = N_RANDOM / 3;
    for (int i = 0; i < N_RANDOM; i++) begin
      req.value    = pick_value();
      req.idle_pct = (i < third) ? 27 : (i < 2 * third) ? 45 : 0;
      req.drain    = (i == 0 || i == third || i == 2 * third || $urandom_range(59, 0) == 0);
      value_q.push_back(req);
    end

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    while (value_q.size() != 0 || accepted_cnt != issued_cnt) @(posedge clk);
    while (digit_q.size() != 0) @(posedge clk);
    // let any stray result show before judging
    repeat (END_CYCLES) @(posedge clk);

    $display("converted %0d values (%0d directed) into %0d digit characters",
             accepted_cnt, N_DIRECTED, digits_seen);
    $display("%0d drain pauses, %0d mismatches", drain_cnt, error_cnt);
    if (error_cnt == 0 && digit_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/bda_pkg.sv
rtl/bda_dpath.sv
rtl/bda_ctrl.sv
rtl/binary_to_decimal_ascii.sv
verif/binary_to_decimal_ascii_tb.sv
